// File: hdl/cpno_pkg.sv
package cpno_pkg;

    // coordinate format
    localparam int CW   = 32;
    localparam int FRAC = 16;

    // normalizer window: largest magnitude kept in [2^LO_B, 2^HI_B); difference lanes are only scaled down
    localparam int HI_B = 30;
    localparam int LO_B = 29;
    localparam int STEP = 4;

    // working widths
    localparam int LW   = 62;            // lane magnitude, covers a full cross product
    localparam int UW   = FRAC + 3;      // signed unit vector component
    localparam int QW   = FRAC + 2;      // quotient bits
    localparam int NW   = HI_B + FRAC + 1;
    localparam int RW   = 31;            // root and divisor width
    localparam int CNTW = $clog2(QW + 1);

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_DEGEN = 2'd2;

    typedef struct packed {
        logic start;
        logic is_div;
    } rd_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rd_stat_t;

endpackage

// File: hdl/cpno_if.sv
interface cpno_pt_if;
    import cpno_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic                 last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface cpno_res_if;
    import cpno_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic [1:0]           status;
    logic                 end_of_run;

    modport source (output valid, out_x, out_y, out_z, status, end_of_run, input ready);
    modport sink   (input valid, out_x, out_y, out_z, status, end_of_run, output ready);
endinterface

// File: hdl/cpno_mul.sv
module cpno_mul (
    input  logic                            clk,
    input  logic signed [cpno_pkg::CW-1:0]  a,
    input  logic signed [cpno_pkg::CW-1:0]  b,
    output logic signed [2*cpno_pkg::CW-1:0] prod
);
    import cpno_pkg::*;

    logic signed [2*CW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: hdl/cpno_rootdiv.sv
module cpno_rootdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cpno_pkg::rd_cmd_t           cmd,
    input  logic [cpno_pkg::LW-1:0]     rad,
    input  logic [cpno_pkg::HI_B-1:0]   wmag,
    input  logic [cpno_pkg::RW-1:0]     len,
    output cpno_pkg::rd_stat_t          stat,
    output logic [cpno_pkg::RW-1:0]     res
);
    import cpno_pkg::*;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            div_reg, div_next;
    logic [LW-1:0]   x_reg, x_next;
    logic [LW-1:0]   r_reg, r_next;
    logic [LW-1:0]   bit_reg, bit_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   numl_reg, numl_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [RW-1:0]   dvs_reg, dvs_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]   res_reg, res_next;

    logic [LW:0]     t_sq;
    logic            ge_sq;
    logic [NW-1:0]   nsum;
    logic [RW:0]     t_dv;
    logic [RW:0]     dv_sub;
    logic            ge_dv;

    always_comb
    begin
        t_sq   = {1'b0, r_reg} + {1'b0, bit_reg};
        ge_sq  = {1'b0, x_reg} >= t_sq;
        // numerator with half the divisor folded in for round-half-up
        nsum   = NW'({wmag, {FRAC{1'b0}}}) + NW'(len[RW-1:1]);
        t_dv   = {rem_reg, numl_reg[QW-1]};
        ge_dv  = t_dv >= {1'b0, dvs_reg};
        dv_sub = t_dv - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        numl_next = numl_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            div_next  = cmd.is_div;
            x_next    = rad;
            r_next    = '0;
            bit_next  = LW'(1) << (LW - 2);
            rem_next  = RW'(nsum[NW-1:QW]);
            numl_next = nsum[QW-1:0];
            q_next    = '0;
            dvs_next  = len;
            cnt_next  = CNTW'(QW);
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_next  = ge_dv ? dv_sub[RW-1:0] : t_dv[RW-1:0];
                numl_next = {numl_reg[QW-2:0], 1'b0};
                q_next    = {q_reg[QW-2:0], ge_dv};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    res_next  = RW'(q_next);
                end
            end
            else
            begin
                if (ge_sq)
                begin
                    x_next = x_reg - t_sq[LW-1:0];
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    res_next  = r_next[RW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        numl_reg <= numl_next;
        q_reg    <= q_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = res_reg;

endmodule

// File: hdl/control_polygon_normal_offset.sv
// Offsets a stream of 3-D control points (signed Q16.16) along the in-plane
// normal of each three-point window. One point is taken at a time and the
// input stays not ready until every result of that point has been loaded into
// the output register, which also waits out any output stall. Once the curve
// has three points, the work per point is set by the single root/divide unit,
// which yields one bit a cycle: three square roots of 31 steps and nine
// quotients of FRAC+2 steps per window (a collinear window needs none), with
// cross products, squares and offset products sharing one registered 32x32
// multiplier. The offset register may only be written while the block is idle.
module control_polygon_normal_offset (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cpno_pkg::CW-1:0]     cfg_wr_data,
    cpno_pt_if.sink                     point,
    cpno_res_if.source                  result
);
    import cpno_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DNORM, S_PROD, S_PDONE, S_NNORM, S_UNORM,
        S_SQRT, S_DSTART, S_DIV, S_UNEXT, S_OUT, S_ERR
    } state_t;

    typedef enum logic [2:0] {K_N, K_C0, K_C1, K_SQ, K_EM} kind_t;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [UW-1:0] unit_t;
    typedef logic signed [2*CW-1:0] acc_t;

    state_t        state_reg, state_next;
    kind_t         kind_reg, kind_next;
    logic [2:0]    pc_reg, pc_next;
    coord_t        off_reg, off_next;
    logic [1:0]    pts_reg, pts_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    which_reg, which_next;
    logic [1:0]    comp_reg, comp_next;
    logic [1:0]    ridx_reg, ridx_next;

    coord_t        old_reg[3], old_next[3];
    coord_t        new_reg[3], new_next[3];
    coord_t        p_reg[3], p_next[3];
    logic          last_reg, last_next;
    logic [LW-1:0] lmag_reg[6], lmag_next[6];
    logic          lneg_reg[6], lneg_next[6];
    coord_t        ds_reg[6], ds_next[6];
    coord_t        ns_reg[3], ns_next[3];
    acc_t          acc_reg[3], acc_next[3];
    unit_t         u_reg[3][3], u_next[3][3];
    logic          ok_reg[3], ok_next[3];
    logic [RW-1:0] len_reg, len_next;
    coord_t        o_reg[3], o_next[3];
    logic [1:0]    ostat_reg, ostat_next;
    logic          oeor_reg, oeor_next;

    coord_t        mul_a, mul_b;
    acc_t          mul_p;
    rd_cmd_t       rd_cmd;
    rd_stat_t      rd_stat;
    logic [HI_B-1:0] rd_wmag;
    logic [RW-1:0] rd_res;

    function automatic logic [4:0] xtab(input logic [2:0] j);
        logic [4:0] r;
        // {a index, b index, subtract}
        case (j)
            3'd0:    r = {2'd1, 2'd2, 1'b0};
            3'd1:    r = {2'd2, 2'd1, 1'b1};
            3'd2:    r = {2'd2, 2'd0, 1'b0};
            3'd3:    r = {2'd0, 2'd2, 1'b1};
            3'd4:    r = {2'd0, 2'd1, 1'b0};
            default: r = {2'd1, 2'd0, 1'b1};
        endcase
        return r;
    endfunction

    function automatic coord_t lane_val(input logic [LW-1:0] m, input logic neg);
        coord_t v;
        v = coord_t'(m[CW-1:0]);
        return neg ? -v : v;
    endfunction

    function automatic coord_t sat_out(input acc_t prod, input coord_t base);
        logic [2*CW-1:0] pm;
        logic [2*CW-1:0] rnd;
        acc_t            sv;
        pm  = prod[2*CW-1] ? $unsigned(-prod) : $unsigned(prod);
        rnd = (pm + ((2*CW)'(1) << (FRAC - 1))) >> FRAC;
        sv  = acc_t'({{CW{base[CW-1]}}, base});
        sv  = prod[2*CW-1] ? sv - acc_t'(rnd) : sv + acc_t'(rnd);
        if (sv[2*CW-1:CW-1] != '0 && sv[2*CW-1:CW-1] != '1)
        begin
            return sv[2*CW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return sv[CW-1:0];
    endfunction

    cpno_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    cpno_rootdiv u_rootdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rd_cmd),
        .rad   (acc_reg[0][LW-1:0]),
        .wmag  (rd_wmag),
        .len   (len_reg),
        .stat  (rd_stat),
        .res   (rd_res)
    );

    // normalizer over the lanes
    logic          six;
    logic          nrun;
    logic [LW-1:0] orm;
    logic          nzero, rsh4, rsh1, lsh4, ndone;

    always_comb
    begin
        six  = state_reg == S_DNORM;
        nrun = state_reg == S_DNORM || state_reg == S_NNORM || state_reg == S_UNORM;
        orm  = lmag_reg[0] | lmag_reg[1] | lmag_reg[2];
        if (six)
        begin
            orm = orm | lmag_reg[3] | lmag_reg[4] | lmag_reg[5];
        end
        nzero = orm == '0;
        rsh4  = |orm[LW-1:HI_B+STEP];
        rsh1  = |orm[LW-1:HI_B];
        lsh4  = orm[LW-1:LO_B-STEP] == '0;
        ndone = nzero || (!rsh1 && (six || orm[LO_B]));
    end

    // product sequencing
    logic [4:0]  tab;
    logic [1:0]  jx;
    logic [2:0]  jp;
    logic [2:0]  pcnt;
    logic [1:0]  usel;
    coord_t      av[3], bv[3];

    always_comb
    begin
        tab  = xtab(pc_reg);
        jx   = (pc_reg < 3'd3) ? pc_reg[1:0] : 2'd0;
        jp   = pc_reg - 3'd1;
        pcnt = (kind_reg == K_SQ || kind_reg == K_EM) ? 3'd3 : 3'd6;
        usel = (ridx_reg == 2'd0) ? 2'd0 : (ridx_reg == 2'd1) ? 2'd2 : 2'd1;
        for (int i = 0; i < 3; i++)
        begin
            av[i] = (kind_reg == K_C1) ? ds_reg[i+3] : ds_reg[i];
            bv[i] = (kind_reg == K_N) ? ds_reg[i+3] : ns_reg[i];
        end
        unique case (kind_reg)
            K_SQ:
            begin
                mul_a = lane_val(lmag_reg[jx], lneg_reg[jx]);
                mul_b = mul_a;
            end
            K_EM:
            begin
                mul_a = off_reg;
                mul_b = coord_t'({{(CW-UW){u_reg[usel][jx][UW-1]}}, u_reg[usel][jx]});
            end
            default:
            begin
                mul_a = av[tab[4:3]];
                mul_b = bv[tab[2:1]];
            end
        endcase
        rd_wmag = lmag_reg[comp_reg][HI_B-1:0];
    end

    logic          out_free;
    logic          eor;
    coord_t        base[3];
    logic signed [UW:0] ssum[3];
    logic [UW:0]   smag[3];
    logic [CW:0]   dd[6];
    logic [1:0]    ci;

    always_comb
    begin
        out_free = !ovalid_reg || result.ready;
        eor      = ridx_reg == 2'd2 || (ridx_reg == 2'd1 && !last_reg);
        for (int i = 0; i < 3; i++)
        begin
            base[i] = (ridx_reg == 2'd0) ? old_reg[i] :
                      (ridx_reg == 2'd1) ? new_reg[i] : p_reg[i];
            ssum[i] = {u_reg[0][i][UW-1], u_reg[0][i]} + {u_reg[1][i][UW-1], u_reg[1][i]};
            smag[i] = ssum[i][UW] ? $unsigned(-ssum[i]) : $unsigned(ssum[i]);
        end
        dd[0] = {point.point_x[CW-1], point.point_x} - {new_reg[0][CW-1], new_reg[0]};
        dd[1] = {point.point_y[CW-1], point.point_y} - {new_reg[1][CW-1], new_reg[1]};
        dd[2] = {point.point_z[CW-1], point.point_z} - {new_reg[2][CW-1], new_reg[2]};
        for (int i = 0; i < 3; i++)
        begin
            dd[i+3] = dd[i];
            dd[i]   = {new_reg[i][CW-1], new_reg[i]} - {old_reg[i][CW-1], old_reg[i]};
        end
        ci = (kind_reg == K_C0 || kind_reg == K_C1 || kind_reg == K_N) ? jp[2:1] :
             (kind_reg == K_SQ) ? 2'd0 : jp[1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        pc_next     = pc_reg;
        off_next    = off_reg;
        pts_next    = pts_reg;
        ovalid_next = ovalid_reg;
        which_next  = which_reg;
        comp_next   = comp_reg;
        ridx_next   = ridx_reg;
        last_next   = last_reg;
        len_next    = len_reg;
        ostat_next  = ostat_reg;
        oeor_next   = oeor_reg;
        old_next    = old_reg;
        new_next    = new_reg;
        p_next      = p_reg;
        lmag_next   = lmag_reg;
        lneg_next   = lneg_reg;
        ds_next     = ds_reg;
        ns_next     = ns_reg;
        acc_next    = acc_reg;
        u_next      = u_reg;
        ok_next     = ok_reg;
        o_next      = o_reg;
        rd_cmd      = '0;

        if (cfg_wr_en)
        begin
            off_next = coord_t'(cfg_wr_data);
        end
        if (ovalid_reg && result.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (nrun && !ndone)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (i < 3 || six)
                begin
                    if (rsh4)
                        lmag_next[i] = lmag_reg[i] >> STEP;
                    else if (rsh1)
                        lmag_next[i] = lmag_reg[i] >> 1;
                    else if (lsh4)
                        lmag_next[i] = lmag_reg[i] << STEP;
                    else
                        lmag_next[i] = lmag_reg[i] << 1;
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (point.valid)
                begin
                    p_next[0] = point.point_x;
                    p_next[1] = point.point_y;
                    p_next[2] = point.point_z;
                    last_next = point.last_point;
                    if (pts_reg < 2'd2)
                    begin
                        old_next = new_reg;
                        new_next[0] = point.point_x;
                        new_next[1] = point.point_y;
                        new_next[2] = point.point_z;
                        pts_next = pts_reg + 2'd1;
                        if (point.last_point)
                            state_next = S_ERR;
                    end
                    else
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            lneg_next[i] = dd[i][CW];
                            lmag_next[i] = LW'(dd[i][CW] ? $unsigned(-dd[i]) : $unsigned(dd[i]));
                        end
                        state_next = S_DNORM;
                    end
                end
            end
            S_DNORM:
            begin
                if (ndone)
                begin
                    for (int i = 0; i < 6; i++)
                        ds_next[i] = lane_val(lmag_reg[i], lneg_reg[i]);
                    kind_next  = K_N;
                    pc_next    = '0;
                    acc_next   = '{default: '0};
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                if (pc_reg != 3'd0)
                begin
                    if (kind_reg != K_SQ && kind_reg != K_EM && jp[0])
                        acc_next[ci] = acc_reg[ci] - mul_p;
                    else
                        acc_next[ci] = acc_reg[ci] + mul_p;
                end
                if (pc_reg == pcnt)
                    state_next = S_PDONE;
                else
                    pc_next = pc_reg + 3'd1;
            end
            S_PDONE:
            begin
                unique case (kind_reg)
                    K_N, K_C0:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            lneg_next[i] = acc_reg[i][2*CW-1];
                            lmag_next[i] = LW'(acc_reg[i][2*CW-1] ? $unsigned(-acc_reg[i])
                                                                  : $unsigned(acc_reg[i]));
                        end
                        if (kind_reg == K_N)
                        begin
                            state_next = S_NNORM;
                        end
                        else
                        begin
                            kind_next  = K_C1;
                            pc_next    = '0;
                            acc_next   = '{default: '0};
                            state_next = S_PROD;
                        end
                    end
                    K_C1:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            lneg_next[i+3] = acc_reg[i][2*CW-1];
                            lmag_next[i+3] = LW'(acc_reg[i][2*CW-1] ? $unsigned(-acc_reg[i])
                                                                    : $unsigned(acc_reg[i]));
                        end
                        which_next = 2'd0;
                        state_next = S_UNORM;
                    end
                    K_SQ:
                    begin
                        rd_cmd.start  = 1'b1;
                        rd_cmd.is_div = 1'b0;
                        state_next    = S_SQRT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_NNORM:
            begin
                if (ndone)
                begin
                    if (nzero)
                    begin
                        // collinear window: no direction anywhere
                        u_next    = '{default: '{default: '0}};
                        ok_next   = '{default: 1'b0};
                        ridx_next = (pts_reg == 2'd2) ? 2'd0 : 2'd1;
                        kind_next = K_EM;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            ns_next[i] = lane_val(lmag_reg[i], lneg_reg[i]);
                        kind_next = K_C0;
                    end
                    pc_next    = '0;
                    acc_next   = '{default: '0};
                    state_next = S_PROD;
                end
            end
            S_UNORM:
            begin
                if (ndone)
                begin
                    if (nzero)
                    begin
                        u_next[which_reg]  = '{default: '0};
                        ok_next[which_reg] = 1'b0;
                        state_next         = S_UNEXT;
                    end
                    else
                    begin
                        ok_next[which_reg] = 1'b1;
                        kind_next          = K_SQ;
                        pc_next            = '0;
                        acc_next           = '{default: '0};
                        state_next         = S_PROD;
                    end
                end
            end
            S_SQRT:
            begin
                if (rd_stat.done)
                begin
                    len_next   = rd_res;
                    comp_next  = 2'd0;
                    state_next = S_DSTART;
                end
            end
            S_DSTART:
            begin
                rd_cmd.start  = 1'b1;
                rd_cmd.is_div = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (rd_stat.done)
                begin
                    u_next[which_reg][comp_reg] = lneg_reg[comp_reg] ? -unit_t'(rd_res[QW-1:0])
                                                                     : unit_t'(rd_res[QW-1:0]);
                    if (comp_reg == 2'd2)
                    begin
                        state_next = S_UNEXT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_UNEXT:
            begin
                unique case (which_reg)
                    2'd0:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            lmag_next[i] = lmag_reg[i+3];
                            lneg_next[i] = lneg_reg[i+3];
                        end
                        which_next = 2'd1;
                        state_next = S_UNORM;
                    end
                    2'd1:
                    begin
                        // mean direction: normalizing the plain sum
                        for (int i = 0; i < 3; i++)
                        begin
                            lmag_next[i] = LW'(smag[i]);
                            lneg_next[i] = ssum[i][UW];
                        end
                        which_next = 2'd2;
                        state_next = S_UNORM;
                    end
                    default:
                    begin
                        ridx_next  = (pts_reg == 2'd2) ? 2'd0 : 2'd1;
                        kind_next  = K_EM;
                        pc_next    = '0;
                        acc_next   = '{default: '0};
                        state_next = S_PROD;
                    end
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                        o_next[i] = sat_out(acc_reg[i], base[i]);
                    ostat_next = ok_reg[usel] ? STAT_OK : STAT_DEGEN;
                    oeor_next  = eor;
                    if (eor)
                    begin
                        if (last_reg)
                        begin
                            pts_next = 2'd0;
                        end
                        else
                        begin
                            old_next = new_reg;
                            new_next = p_reg;
                            pts_next = 2'd3;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ridx_next  = ridx_reg + 2'd1;
                        pc_next    = '0;
                        acc_next   = '{default: '0};
                        state_next = S_PROD;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    o_next      = '{default: '0};
                    ostat_next  = STAT_SHORT;
                    oeor_next   = 1'b1;
                    pts_next    = 2'd0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= K_N;
            pc_reg     <= '0;
            off_reg    <= '0;
            pts_reg    <= '0;
            ovalid_reg <= 1'b0;
            which_reg  <= '0;
            comp_reg   <= '0;
            ridx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            pc_reg     <= pc_next;
            off_reg    <= off_next;
            pts_reg    <= pts_next;
            ovalid_reg <= ovalid_next;
            which_reg  <= which_next;
            comp_reg   <= comp_next;
            ridx_reg   <= ridx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_reg   <= old_next;
        new_reg   <= new_next;
        p_reg     <= p_next;
        last_reg  <= last_next;
        lmag_reg  <= lmag_next;
        lneg_reg  <= lneg_next;
        ds_reg    <= ds_next;
        ns_reg    <= ns_next;
        acc_reg   <= acc_next;
        u_reg     <= u_next;
        ok_reg    <= ok_next;
        len_reg   <= len_next;
        o_reg     <= o_next;
        ostat_reg <= ostat_next;
        oeor_reg  <= oeor_next;
    end

    assign point.ready       = state_reg == S_IDLE;
    assign result.valid      = ovalid_reg;
    assign result.out_x      = o_reg[0];
    assign result.out_y      = o_reg[1];
    assign result.out_z      = o_reg[2];
    assign result.status     = ostat_reg;
    assign result.end_of_run = oeor_reg;

`ifndef SYNTHESIS
    a_rd_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cmd.start |-> !rd_stat.busy)
        else $error("root/divide unit restarted while busy");

    a_ds_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROD && kind_reg == K_N) |->
        (ds_reg[0] < 32'sh4000_0000 && ds_reg[0] > -32'sh4000_0000 &&
         ds_reg[1] < 32'sh4000_0000 && ds_reg[1] > -32'sh4000_0000 &&
         ds_reg[2] < 32'sh4000_0000 && ds_reg[2] > -32'sh4000_0000 &&
         ds_reg[3] < 32'sh4000_0000 && ds_reg[3] > -32'sh4000_0000 &&
         ds_reg[4] < 32'sh4000_0000 && ds_reg[4] > -32'sh4000_0000 &&
         ds_reg[5] < 32'sh4000_0000 && ds_reg[5] > -32'sh4000_0000))
        else $error("difference vectors not rescaled");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ostat_reg == STAT_SHORT) |->
        (o_reg[0] == '0 && o_reg[1] == '0 && o_reg[2] == '0 && oeor_reg))
        else $error("short curve result carries data");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT || state_reg == S_DIV) |-> !point.ready)
        else $error("input taken during normal computation");
`endif

endmodule

// File: tb/control_polygon_normal_offset_tb.sv
`timescale 1ns / 1ps

module control_polygon_normal_offset_tb;
    import cpno_pkg::*;

    localparam int  LIMIT_CYCLES = 2000000;
    localparam int  SETTLE = 600;      // longer than one window of work
    localparam int  N_RANDOM = 256;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         st;
        logic               eor;
    } offs_pt_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
        bit                 known;
        offs_pt_t           res;
    } row_t;

    typedef longint vec3_t [3];
    typedef longint vec6_t [6];

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    cpno_pt_if  point ();
    cpno_res_if result ();

    control_polygon_normal_offset uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .point       (point.sink),
        .result      (result.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    longint   pm_offs;
    vec3_t    pm_older;
    vec3_t    pm_newer;
    int       pm_seen;
    offs_pt_t expected_pts [$];
    row_t     dir_rows [$];

    int  errors;
    int  n_results;
    int  n_items;
    int  cycles;
    int  idle_mode;     // 0 none, 1 sender, 2 receiver, 3 both
    bit  known_pending;
    offs_pt_t known_res;

    function automatic logic [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(logic [63:0] m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit rescale_vec(input vec6_t src, input int cnt, input bit up,
                                       output vec6_t dst);
        logic [63:0] m;
        logic [63:0] a;
        int rs;
        int ls;
        m = 0;
        rs = 0;
        ls = 0;
        for (int i = 0; i < 6; i++)
            dst[i] = 0;
        for (int i = 0; i < cnt; i++)
            if (magn(src[i]) > m)
                m = magn(src[i]);
        if (m == 0)
            return 1'b0;
        while ((m >> rs) >= (64'd1 << HI_B))
            rs++;
        if (up)
            while ((m << ls) < (64'd1 << LO_B))
                ls++;
        for (int i = 0; i < cnt; i++)
        begin
            a = magn(src[i]);
            a = (rs != 0) ? (a >> rs) : (a << ls);
            dst[i] = signed_of(a, src[i] < 0);
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit unit_dir(input vec3_t v, output vec3_t u);
        vec6_t t;
        vec6_t w;
        logic [63:0] len;
        logic [63:0] q;
        for (int i = 0; i < 6; i++)
            t[i] = (i < 3) ? v[i] : 0;
        u = '{0, 0, 0};
        if (!rescale_vec(t, 3, 1'b1, w))
            return 1'b0;
        len = int_root(64'(w[0] * w[0]) + 64'(w[1] * w[1]) + 64'(w[2] * w[2]));
        for (int i = 0; i < 3; i++)
        begin
            q = ((magn(w[i]) << FRAC) + (len >> 1)) / len;
            u[i] = signed_of(q, w[i] < 0);
        end
        return 1'b1;
    endfunction

    function automatic vec3_t xprod(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic offs_pt_t moved_point(vec3_t p, vec3_t u, bit ok);
        offs_pt_t o;
        longint prod;
        longint v [3];
        logic [63:0] m;
        for (int i = 0; i < 3; i++)
        begin
            prod = pm_offs * u[i];
            m = (magn(prod) + (64'd1 << (FRAC - 1))) >> FRAC;
            v[i] = p[i] + signed_of(m, prod < 0);
            if (v[i] > 64'sd2147483647)
                v[i] = 64'sd2147483647;
            if (v[i] < -64'sd2147483648)
                v[i] = -64'sd2147483648;
        end
        o.x = v[0][31:0];
        o.y = v[1][31:0];
        o.z = v[2][31:0];
        o.st = ok ? STAT_OK : STAT_DEGEN;
        o.eor = 1'b0;
        return o;
    endfunction

    // work out the offset points caused by one accepted control point
    task automatic predict_offsets(input logic signed [31:0] px, py, pz, input logic last);
        vec3_t p, d0, d1, n, c0, c1, s, u0, um, u1;
        vec6_t d, ds, nt, ns;
        bit ok0, okm, ok1;
        offs_pt_t o [$];
        offs_pt_t sh;
        p = '{longint'(px), longint'(py), longint'(pz)};
        if (pm_seen < 2)
        begin
            pm_older = pm_newer;
            pm_newer = p;
            pm_seen++;
            if (last)
            begin
                sh = '{0, 0, 0, STAT_SHORT, 1'b1};
                expected_pts.insert(expected_pts.size(), sh);
                pm_older = '{0, 0, 0};
                pm_newer = '{0, 0, 0};
                pm_seen = 0;
            end
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            d[i] = pm_newer[i] - pm_older[i];
            d[i + 3] = p[i] - pm_newer[i];
        end
        void'(rescale_vec(d, 6, 1'b0, ds));
        d0 = '{ds[0], ds[1], ds[2]};
        d1 = '{ds[3], ds[4], ds[5]};
        n = xprod(d0, d1);
        nt = '{n[0], n[1], n[2], 0, 0, 0};
        if (!rescale_vec(nt, 3, 1'b1, ns))
        begin
            u0 = '{0, 0, 0};
            um = '{0, 0, 0};
            u1 = '{0, 0, 0};
            ok0 = 0;
            okm = 0;
            ok1 = 0;
        end
        else
        begin
            n = '{ns[0], ns[1], ns[2]};
            c0 = xprod(d0, n);
            c1 = xprod(d1, n);
            ok0 = unit_dir(c0, u0);
            ok1 = unit_dir(c1, u1);
            for (int i = 0; i < 3; i++)
                s[i] = u0[i] + u1[i];
            okm = unit_dir(s, um);
        end
        if (pm_seen == 2)
            o.insert(o.size(), moved_point(pm_older, u0, ok0));
        o.insert(o.size(), moved_point(pm_newer, um, okm));
        if (last)
            o.insert(o.size(), moved_point(p, u1, ok1));
        o[o.size() - 1].eor = 1'b1;
        foreach (o[i])
            expected_pts.insert(expected_pts.size(), o[i]);
        if (last)
        begin
            pm_older = '{0, 0, 0};
            pm_newer = '{0, 0, 0};
            pm_seen = 0;
        end
        else
        begin
            pm_older = pm_newer;
            pm_newer = p;
            pm_seen = 3;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, exp);
        errors++;
        $display("mismatch at result %0d: %s got %h expected %h", n_results, what, got, exp);
    endtask

    function automatic bit idle_now(bit sender);
        if (idle_mode == 3)
            return $urandom_range(99) < 12;
        if (sender && idle_mode == 1)
            return $urandom_range(99) < 47;
        if (!sender && idle_mode == 2)
            return $urandom_range(99) < 47;
        return 1'b0;
    endfunction

    // result side: check accepted results, then pick ready for next cycle
    always @(posedge clk)
    begin
        offs_pt_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_pts.size() == 0)
            begin
                errors++;
                $display("unexpected result %h %h %h st %0d", result.out_x, result.out_y,
                         result.out_z, result.status);
            end
            else
            begin
                e = expected_pts.pop_front();
                if (result.out_x !== e.x)
                    report_mismatch("out_x", result.out_x, e.x);
                if (result.out_y !== e.y)
                    report_mismatch("out_y", result.out_y, e.y);
                if (result.out_z !== e.z)
                    report_mismatch("out_z", result.out_z, e.z);
                if (result.status !== e.st)
                    report_mismatch("status", 32'(result.status), 32'(e.st));
                if (result.end_of_run !== e.eor)
                    report_mismatch("end_of_run", 32'(result.end_of_run), 32'(e.eor));
            end
            n_results++;
        end
        result.ready <= !idle_now(1'b0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("control_polygon_normal_offset_tb NOT OK");
            $finish;
        end
    end

    task automatic send_point(input logic signed [31:0] px, py, pz, input logic last);
        while (idle_now(1'b1))
        begin
            point.valid <= 1'b0;
            @(posedge clk);
        end
        point.valid <= 1'b1;
        point.point_x <= px;
        point.point_y <= py;
        point.point_z <= pz;
        point.last_point <= last;
        do
            @(posedge clk);
        while (!point.ready);
        predict_offsets(px, py, pz, last);
        n_items++;
    endtask

    task automatic settle;
        point.valid <= 1'b0;
        while (expected_pts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_offset(input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pm_offs = longint'($signed(v));
        @(posedge clk);
    endtask

    task automatic add_row(input logic signed [31:0] x, y, z, input logic last,
                           input bit known = 0, input offs_pt_t res = '{0, 0, 0, 0, 0});
        row_t r;
        r = '{x, y, z, last, known, res};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    function automatic logic signed [31:0] rnd_coord(int mode);
        case (mode)
            0: return 32'($urandom_range(0, 2000)) - 32'sd1000;
            1: return $signed(32'($urandom_range(0, 400)) - 32'd200) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_curve;
        int len;
        int mode;
        int kind;
        logic signed [31:0] b [3];
        logic signed [31:0] dv [3];
        logic signed [31:0] p [3];
        len = ($urandom_range(99) < 10) ? $urandom_range(1, 2) : $urandom_range(3, 7);
        mode = $urandom_range(2);
        kind = $urandom_range(9);   // 0 collinear, 1 repeated point, else free
        for (int i = 0; i < 3; i++)
        begin
            b[i] = rnd_coord(mode);
            dv[i] = rnd_coord(0);
        end
        for (int k = 0; k < len; k++)
        begin
            for (int i = 0; i < 3; i++)
                p[i] = (kind == 0) ? b[i] + k * dv[i] :
                       (kind == 1 && k == 1) ? b[i] : rnd_coord(mode);
            if (kind != 0 && !(kind == 1 && k == 1))
                b = p;
            // a stray item with last low may leave the curve open into the next one
            send_point(p[0], p[1], p[2], (k == len - 1) && ($urandom_range(19) != 0));
        end
    endtask

    initial
    begin
        logic [31:0] offs_vals [4];
        errors = 0;
        n_results = 0;
        n_items = 0;
        cycles = 0;
        idle_mode = 0;
        pm_offs = 0;
        pm_older = '{0, 0, 0};
        pm_newer = '{0, 0, 0};
        pm_seen = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        point.valid = 1'b0;
        point.point_x = '0;
        point.point_y = '0;
        point.point_z = '0;
        point.last_point = 1'b0;
        result.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short curves, extremes, degenerate windows, plain triangles
        add_row(32'sh7fffffff, 32'sh80000000, 32'sh0, 1'b1, 1, '{0, 0, 0, STAT_SHORT, 1});
        add_row(32'sh80000000, 32'sh7fffffff, 32'shffffffff, 1'b0);
        add_row(32'sh7fffffff, 32'sh80000000, 32'sh12345678, 1'b1, 1,
                '{0, 0, 0, STAT_SHORT, 1});
        add_row(0, 0, 0, 0);
        add_row(32'sh10000, 0, 0, 0);
        add_row(32'sh10000, 32'sh10000, 0, 1);
        add_row(0, 0, 0, 0);
        add_row(32'sh10000, 32'sh10000, 32'sh10000, 0);
        add_row(32'sh20000, 32'sh20000, 32'sh20000, 0);
        add_row(32'sh30000, 32'sh30000, 32'sh30000, 1);
        add_row(5, 5, 5, 0);
        add_row(5, 5, 5, 0);
        add_row(5, 5, 5, 1);
        add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        add_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        add_row(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0);
        add_row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1);
        add_row(0, 0, 0, 0);
        add_row(32'sh40000, 0, 0, 0);
        add_row(32'sh40000, 32'sh40000, 0, 0);
        add_row(0, 32'sh40000, 0, 0);
        add_row(0, 0, 0, 1);

        foreach (dir_rows[i])
        begin
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last);
            if (dir_rows[i].known)
                expected_pts[expected_pts.size() - 1] = dir_rows[i].res;
        end
        settle();
        write_offset(32'h0004_0000);
        foreach (dir_rows[i])
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last);
        settle();

        offs_vals[0] = 32'h7fff_ffff;
        offs_vals[1] = 32'h8000_0000;
        offs_vals[2] = $urandom;
        offs_vals[3] = 32'hfff0_0000;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = ph;
            write_offset(offs_vals[ph]);
            while (n_items < 2 * dir_rows.size() + (ph + 1) * N_RANDOM / 4)
                random_curve();
            // close any open curve so the next phase starts clean
            if (pm_seen != 0)
                send_point(32'sh100, 32'sh200, 32'sh300, 1'b1);
            settle();
        end

        $display("%0d control points sent, %0d offset points checked over 6 offset settings",
                 n_items, n_results);
        $display("idle patterns: none, sender, receiver, both; curves short, degenerate, open");
        if (errors == 0 && expected_pts.size() == 0)
            $display("control_polygon_normal_offset_tb OK");
        else
        begin
            $display("%0d mismatches, %0d results still expected", errors, expected_pts.size());
            $display("control_polygon_normal_offset_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: control_polygon_normal_offset.f
hdl/cpno_pkg.sv
hdl/cpno_if.sv
hdl/cpno_mul.sv
hdl/cpno_rootdiv.sv
hdl/control_polygon_normal_offset.sv
tb/control_polygon_normal_offset_tb.sv
